[rtl/axp_pkg.sv]
// Shared types, constants and the arctangent table of the axis point rotator.
// No dependencies; every other file imports this package.

package axp_pkg;

  localparam int unsigned COORD_W      = 32;
  localparam int unsigned TRIG_FRAC    = 30;
  localparam int unsigned TRIG_W       = 32;
  localparam int unsigned PROD_W       = COORD_W + TRIG_W;
  localparam int unsigned SUM_W        = PROD_W + 1;
  localparam int unsigned SHR_W        = SUM_W - TRIG_FRAC;
  localparam int unsigned ANGLE_W      = 32;
  localparam int unsigned CORDIC_W     = 34;
  localparam int unsigned CORDIC_STEPS = 32;
  localparam int unsigned STEP_W       = 5;
  localparam int unsigned AXIS_W       = 2;
  localparam int unsigned PADDR_W      = 3;
  localparam int unsigned PDATA_W      = 32;

  localparam logic [ANGLE_W-1:0] ANGLE_QUARTER = 32'h4000_0000;
  localparam logic [ANGLE_W-1:0] ANGLE_HALF    = 32'h8000_0000;
  localparam logic [ANGLE_W-1:0] ANGLE_3QUART  = 32'hC000_0000;

  // inverse CORDIC gain in signed Q4.30, rounded half up
  localparam logic signed [CORDIC_W-1:0] CORDIC_K         = 34'sh0_26DD_3B6A;
  localparam logic signed [CORDIC_W-1:0] CORDIC_ONE       = 34'sh0_4000_0000;
  localparam logic signed [CORDIC_W-1:0] CORDIC_MINUS_ONE = -CORDIC_ONE;

  localparam logic signed [TRIG_W-1:0] TRIG_ONE  = TRIG_W'(1) << TRIG_FRAC;
  localparam logic signed [TRIG_W-1:0] TRIG_ZERO = '0;

  localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (TRIG_FRAC - 1);

  typedef enum logic [AXIS_W-1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_e;

  typedef enum logic {
    REG_AXIS_SEL   = 1'b0,
    REG_TURN_ANGLE = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    TRIG_IDLE,
    TRIG_ITER,
    TRIG_FINISH
  } trig_state_e;

  typedef struct packed {
    logic               start;
    logic [ANGLE_W-1:0] angle;
  } trig_req_t;

  typedef struct packed {
    logic                     busy;
    logic signed [TRIG_W-1:0] cos_val;
    logic signed [TRIG_W-1:0] sin_val;
  } trig_rsp_t;

  // atan(2^-i) in binary-angle units, 2^32 per full turn
  function automatic logic [ANGLE_W-1:0] atan_unit(input logic [STEP_W-1:0] idx);
    logic [ANGLE_W-1:0] r;
    case (idx)
      5'd0:    r = 32'h2000_0000;
      5'd1:    r = 32'h12E4_051E;
      5'd2:    r = 32'h09FB_385B;
      5'd3:    r = 32'h0511_11D4;
      5'd4:    r = 32'h028B_0D43;
      5'd5:    r = 32'h0145_D7E1;
      5'd6:    r = 32'h00A2_F61E;
      5'd7:    r = 32'h0051_7C55;
      5'd8:    r = 32'h0028_BE53;
      5'd9:    r = 32'h0014_5F2F;
      5'd10:   r = 32'h000A_2F98;
      5'd11:   r = 32'h0005_17CC;
      5'd12:   r = 32'h0002_8BE6;
      5'd13:   r = 32'h0001_45F3;
      5'd14:   r = 32'h0000_A2FA;
      5'd15:   r = 32'h0000_517D;
      5'd16:   r = 32'h0000_28BE;
      5'd17:   r = 32'h0000_145F;
      5'd18:   r = 32'h0000_0A30;
      5'd19:   r = 32'h0000_0518;
      5'd20:   r = 32'h0000_028C;
      5'd21:   r = 32'h0000_0146;
      5'd22:   r = 32'h0000_00A3;
      5'd23:   r = 32'h0000_0051;
      5'd24:   r = 32'h0000_0029;
      5'd25:   r = 32'h0000_0014;
      5'd26:   r = 32'h0000_000A;
      5'd27:   r = 32'h0000_0005;
      5'd28:   r = 32'h0000_0003;
      5'd29:   r = 32'h0000_0001;
      5'd30:   r = 32'h0000_0001;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

endpackage

[rtl/axp_in_if.sv]
// Point request channel of the axis point rotator: valid/ready plus coordinates.
// Depends on axp_pkg.

interface axp_in_if import axp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;
  logic                      batch_end;

  modport source (output valid, coord_x, coord_y, coord_z, batch_end, input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z, batch_end, output ready);
endinterface

[rtl/axp_out_if.sv]
// Rotated point channel of the axis point rotator: valid/ready plus coordinates.
// Depends on axp_pkg.

interface axp_out_if import axp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] rot_x;
  logic signed [COORD_W-1:0] rot_y;
  logic signed [COORD_W-1:0] rot_z;
  logic                      batch_end_out;

  modport source (output valid, rot_x, rot_y, rot_z, batch_end_out, input ready);
  modport sink   (input valid, rot_x, rot_y, rot_z, batch_end_out, output ready);
endinterface

[rtl/axp_trig.sv]
// Iterative CORDIC: sine and cosine of a binary angle, one micro-rotation a cycle.
// Depends on axp_pkg; holds the cosine and sine used by the rotation datapath.

module axp_trig import axp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  trig_req_t req_i,
  output trig_rsp_t rsp_o
);

  trig_state_e state_q, state_d;

  logic signed [CORDIC_W-1:0] x_q, x_d;
  logic signed [CORDIC_W-1:0] y_q, y_d;
  logic signed [CORDIC_W-1:0] z_q, z_d;
  logic [STEP_W-1:0]          step_q, step_d;
  logic                       flip_q, flip_d;
  logic signed [TRIG_W-1:0]   cos_q, cos_d;
  logic signed [TRIG_W-1:0]   sin_q, sin_d;

  logic                       flip_in;
  logic [ANGLE_W-1:0]         angle_adj;
  logic signed [CORDIC_W-1:0] dx, dy, atan_w;
  logic signed [CORDIC_W-1:0] xn, yn, xc, yc;

  always_comb begin
    // fold angles beyond a quarter turn by half a turn, negate at the end
    flip_in   = (req_i.angle > ANGLE_QUARTER) && (req_i.angle < ANGLE_3QUART);
    angle_adj = flip_in ? (req_i.angle - ANGLE_HALF) : req_i.angle;

    dx     = y_q >>> step_q;
    dy     = x_q >>> step_q;
    atan_w = $signed({{(CORDIC_W - ANGLE_W){1'b0}}, atan_unit(step_q)});

    xn = flip_q ? -x_q : x_q;
    yn = flip_q ? -y_q : y_q;
    if (xn > CORDIC_ONE) begin
      xc = CORDIC_ONE;
    end else if (xn < CORDIC_MINUS_ONE) begin
      xc = CORDIC_MINUS_ONE;
    end else begin
      xc = xn;
    end
    if (yn > CORDIC_ONE) begin
      yc = CORDIC_ONE;
    end else if (yn < CORDIC_MINUS_ONE) begin
      yc = CORDIC_MINUS_ONE;
    end else begin
      yc = yn;
    end
  end

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    step_d  = step_q;
    flip_d  = flip_q;
    cos_d   = cos_q;
    sin_d   = sin_q;

    if (req_i.start) begin
      state_d = TRIG_ITER;
      x_d     = CORDIC_K;
      y_d     = '0;
      z_d     = $signed({{(CORDIC_W - ANGLE_W){angle_adj[ANGLE_W-1]}}, angle_adj});
      step_d  = '0;
      flip_d  = flip_in;
    end else begin
      unique case (state_q)
        TRIG_IDLE: begin
          state_d = TRIG_IDLE;
        end
        TRIG_ITER: begin
          // a residual angle of zero rotates as positive
          if (!z_q[CORDIC_W-1]) begin
            x_d = x_q - dx;
            y_d = y_q + dy;
            z_d = z_q - atan_w;
          end else begin
            x_d = x_q + dx;
            y_d = y_q - dy;
            z_d = z_q + atan_w;
          end
          step_d = step_q + STEP_W'(1);
          if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
            state_d = TRIG_FINISH;
          end
        end
        TRIG_FINISH: begin
          cos_d   = xc[TRIG_W-1:0];
          sin_d   = yc[TRIG_W-1:0];
          state_d = TRIG_IDLE;
        end
        default: begin
          state_d = TRIG_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TRIG_IDLE;
      step_q  <= '0;
      flip_q  <= 1'b0;
      cos_q   <= TRIG_ONE;
      sin_q   <= TRIG_ZERO;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      flip_q  <= flip_d;
      cos_q   <= cos_d;
      sin_q   <= sin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign rsp_o.busy    = (state_q != TRIG_IDLE);
  assign rsp_o.cos_val = cos_q;
  assign rsp_o.sin_val = sin_q;

endmodule

[rtl/axis_point_rotator_core.sv]
// Axis point rotator: four-stage pipeline (select, multiply, add, round and saturate).
// A request is registered in stages 1 to 4; one request per cycle unless stalled.
// A write of turn_angle holds off requests while the CORDIC runs.
// Reset clears the pipeline; axis_select returns to z, turn_angle to 0, cosine to one.
// Depends on axp_pkg, axp_in_if, axp_out_if and axp_trig.

module axis_point_rotator_core import axp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  axp_in_if.sink              pnt_i,
  axp_out_if.source           pnt_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  // configuration
  axis_e              axis_q;
  logic [ANGLE_W-1:0] angle_q;
  reg_idx_e           reg_idx;
  logic               wr_en;
  trig_req_t          trig_req;
  trig_rsp_t          trig_rsp;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q  <= AXIS_Z;
      angle_q <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_AXIS_SEL:   axis_q  <= axis_e'(pwdata[AXIS_W-1:0]);
        REG_TURN_ANGLE: angle_q <= pwdata[ANGLE_W-1:0];
        default:        axis_q  <= axis_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_AXIS_SEL:   prdata = {{(PDATA_W - AXIS_W){1'b0}}, axis_q};
      REG_TURN_ANGLE: prdata = PDATA_W'(angle_q);
      default:        prdata = '0;
    endcase
  end

  assign trig_req.start = wr_en && (reg_idx == REG_TURN_ANGLE);
  assign trig_req.angle = pwdata[ANGLE_W-1:0];

  axp_trig u_trig (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (trig_req),
    .rsp_o  (trig_rsp)
  );

  // stage handshakes: a stage loads when empty or when the next one moves
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  logic in_fire;

  assign rdy4        = !v4_q || pnt_o.ready;
  assign rdy3        = !v3_q || rdy4;
  assign rdy2        = !v2_q || rdy3;
  assign rdy1        = !v1_q || rdy2;
  assign pnt_i.ready = rdy1 && !trig_rsp.busy;
  assign in_fire     = pnt_i.valid && pnt_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_fire;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // stage 1: pick the two rotated coordinates
  logic signed [COORD_W-1:0] s1_a_q, s1_b_q, s1_x_q, s1_y_q, s1_z_q;
  axis_e                     s1_axis_q;
  logic                      s1_last_q;
  logic signed [COORD_W-1:0] sel_a, sel_b;

  always_comb begin
    unique case (axis_q)
      AXIS_X:  begin sel_a = pnt_i.coord_y; sel_b = pnt_i.coord_z; end
      AXIS_Y:  begin sel_a = pnt_i.coord_x; sel_b = pnt_i.coord_z; end
      default: begin sel_a = pnt_i.coord_x; sel_b = pnt_i.coord_y; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_a_q    <= sel_a;
      s1_b_q    <= sel_b;
      s1_x_q    <= pnt_i.coord_x;
      s1_y_q    <= pnt_i.coord_y;
      s1_z_q    <= pnt_i.coord_z;
      s1_axis_q <= axis_q;
      s1_last_q <= pnt_i.batch_end;
    end
  end

  // stage 2: four exact products
  logic signed [PROD_W-1:0]  s2_ca_q, s2_sb_q, s2_sa_q, s2_cb_q;
  logic signed [COORD_W-1:0] s2_x_q, s2_y_q, s2_z_q;
  axis_e                     s2_axis_q;
  logic                      s2_last_q;

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      s2_ca_q   <= PROD_W'(trig_rsp.cos_val) * PROD_W'(s1_a_q);
      s2_sb_q   <= PROD_W'(trig_rsp.sin_val) * PROD_W'(s1_b_q);
      s2_sa_q   <= PROD_W'(trig_rsp.sin_val) * PROD_W'(s1_a_q);
      s2_cb_q   <= PROD_W'(trig_rsp.cos_val) * PROD_W'(s1_b_q);
      s2_x_q    <= s1_x_q;
      s2_y_q    <= s1_y_q;
      s2_z_q    <= s1_z_q;
      s2_axis_q <= s1_axis_q;
      s2_last_q <= s1_last_q;
    end
  end

  // stage 3: combine products and add the rounding half
  logic [SUM_W-1:0]          s3_f_q, s3_s_q;
  logic signed [COORD_W-1:0] s3_x_q, s3_y_q, s3_z_q;
  axis_e                     s3_axis_q;
  logic                      s3_last_q;

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      s3_f_q    <= SUM_W'(s2_ca_q) - SUM_W'(s2_sb_q) + ROUND_HALF;
      s3_s_q    <= SUM_W'(s2_sa_q) + SUM_W'(s2_cb_q) + ROUND_HALF;
      s3_x_q    <= s2_x_q;
      s3_y_q    <= s2_y_q;
      s3_z_q    <= s2_z_q;
      s3_axis_q <= s2_axis_q;
      s3_last_q <= s2_last_q;
    end
  end

  // stage 4: drop the fraction, saturate, place into the output register
  function automatic logic [COORD_W-1:0] sat_coord(input logic [SHR_W-1:0] v);
    logic [COORD_W-1:0] r;
    if ((&v[SHR_W-1:COORD_W-1]) || !(|v[SHR_W-1:COORD_W-1])) begin
      r = v[COORD_W-1:0];
    end else if (v[SHR_W-1]) begin
      r = {1'b1, {(COORD_W - 1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W - 1){1'b1}}};
    end
    return r;
  endfunction

  logic signed [COORD_W-1:0] rf, rs;
  logic signed [COORD_W-1:0] ox_d, oy_d, oz_d;
  logic signed [COORD_W-1:0] ox_q, oy_q, oz_q;
  logic                      olast_q;

  assign rf = $signed(sat_coord(s3_f_q[SUM_W-1:TRIG_FRAC]));
  assign rs = $signed(sat_coord(s3_s_q[SUM_W-1:TRIG_FRAC]));

  always_comb begin
    unique case (s3_axis_q)
      AXIS_X:  begin ox_d = s3_x_q; oy_d = rf;     oz_d = rs;     end
      AXIS_Y:  begin ox_d = rf;     oy_d = s3_y_q; oz_d = rs;     end
      AXIS_Z:  begin ox_d = rf;     oy_d = rs;     oz_d = s3_z_q; end
      default: begin ox_d = s3_x_q; oy_d = s3_y_q; oz_d = s3_z_q; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      ox_q    <= ox_d;
      oy_q    <= oy_d;
      oz_q    <= oz_d;
      olast_q <= s3_last_q;
    end
  end

  assign pnt_o.valid         = v4_q;
  assign pnt_o.rot_x         = ox_q;
  assign pnt_o.rot_y         = oy_q;
  assign pnt_o.rot_z         = oz_q;
  assign pnt_o.batch_end_out = olast_q;

endmodule

[rtl/axp_checker.sv]
// Port-level assertions for axis_point_rotator_core and the bind that attaches them.
// Depends on axp_pkg.

module axp_checker import axp_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic signed [COORD_W-1:0] rot_x_i,
  input logic signed [COORD_W-1:0] rot_y_i,
  input logic signed [COORD_W-1:0] rot_z_i,
  input logic                      last_i,
  input logic                      psel_i,
  input logic                      penable_i,
  input logic                      pwrite_i,
  input logic [PADDR_W-1:0]        paddr_i,
  input logic [PDATA_W-1:0]        pwdata_i,
  input logic [PDATA_W-1:0]        prdata_i
);

  logic wr_angle;
  assign wr_angle = psel_i && penable_i && pwrite_i && (paddr_i[2] == REG_TURN_ANGLE);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable({rot_x_i, rot_y_i, rot_z_i, last_i}))
    else $error("result changed while stalled");

  // an angle write holds off requests while sine and cosine are rebuilt
  a_angle_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_angle |=> !in_ready_i ##1 !in_ready_i)
    else $error("request accepted during trig update");

  // the angle register reads back what was written
  a_angle_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_angle |=> (paddr_i[2] != REG_TURN_ANGLE) || (prdata_i == $past(pwdata_i)))
    else $error("turn_angle readback mismatch");

endmodule

bind axis_point_rotator_core axp_checker u_axp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (pnt_i.ready),
  .out_valid_i (pnt_o.valid),
  .out_ready_i (pnt_o.ready),
  .rot_x_i     (pnt_o.rot_x),
  .rot_y_i     (pnt_o.rot_y),
  .rot_z_i     (pnt_o.rot_z),
  .last_i      (pnt_o.batch_end_out),
  .psel_i      (psel),
  .penable_i   (penable),
  .pwrite_i    (pwrite),
  .paddr_i     (paddr),
  .pwdata_i    (pwdata),
  .prdata_i    (prdata)
);

[verif/axp_rotation_checker.sv]
`timescale 1ns / 100ps
// Scoreboard of the axis point rotator: predicts each rotated point and compares it.
// Depends on axp_pkg, axp_in_if and axp_out_if; watches the APB port for settings.

module axp_rotation_checker import axp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  axp_in_if                  pnt_in,
  axp_out_if                 pnt_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output int                 fail_count,
  output int                 pending,
  output int                 points_checked,
  output int                 writes_seen
);

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      last;
  } rotated_point_t;

  // atan(2^-i) in binary-angle units
  localparam logic [0:31][31:0] ATAN_UNITS = {
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
    32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2F,
    32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA,
    32'h0000_517D, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051, 32'h0000_0029,
    32'h0000_0014, 32'h0000_000A, 32'h0000_0005, 32'h0000_0003, 32'h0000_0001,
    32'h0000_0001, 32'h0000_0000
  };

  // inverse gain 0x9B74EDA8 in Q0.32, rounded half up to the trig fraction
  localparam logic signed [63:0] GAIN_INV =
    (64'h9B74_EDA8 + (64'd1 << (31 - TRIG_FRAC))) >> (32 - TRIG_FRAC);
  localparam logic signed [63:0] TRIG_UNITY = 64'sd1 <<< TRIG_FRAC;

  axis_e             rot_axis = AXIS_Z;
  logic signed [63:0] cos_q   = TRIG_UNITY;
  logic signed [63:0] sin_q   = '0;
  rotated_point_t    expected_q[$];
  int                errs     = 0;
  int                cmp_count = 0;
  int                n_writes = 0;

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    errs++;
    $display("mismatch on %s: expected %h, got %h at %0t", what, want, got, $time);
  endtask

  function automatic void derive_trig(input logic [ANGLE_W-1:0] angle);
    logic signed [63:0] x, y, z, t, dx, dy;
    logic [ANGLE_W-1:0] a;
    logic               flip;
    x    = GAIN_INV;
    y    = '0;
    a    = angle;
    flip = 1'b0;
    // beyond a quarter turn either way: rotate by half a turn, negate at the end
    if (a > ANGLE_QUARTER && a < ANGLE_3QUART) begin
      a    = a - ANGLE_HALF;
      flip = 1'b1;
    end
    z = {{32{a[31]}}, a};
    for (int i = 0; i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (!z[63]) begin
        t = x - dx;
        y = y + dy;
        z = z - ATAN_UNITS[i];
      end else begin
        t = x + dx;
        y = y - dy;
        z = z + ATAN_UNITS[i];
      end
      x = t;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    if (x > TRIG_UNITY) x = TRIG_UNITY;
    if (x < -TRIG_UNITY) x = -TRIG_UNITY;
    if (y > TRIG_UNITY) y = TRIG_UNITY;
    if (y < -TRIG_UNITY) y = -TRIG_UNITY;
    cos_q = x;
    sin_q = y;
  endfunction

  function automatic logic signed [COORD_W-1:0] round_sat(input logic signed [95:0] acc);
    logic signed [95:0] q;
    q = (acc + (96'sd1 <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
    if (q > 96'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (q < -96'sh8000_0000) return 32'sh8000_0000;
    return q[COORD_W-1:0];
  endfunction

  function automatic rotated_point_t rotate_point(input logic signed [COORD_W-1:0] px,
                                                  input logic signed [COORD_W-1:0] py,
                                                  input logic signed [COORD_W-1:0] pz,
                                                  input logic last);
    rotated_point_t     r;
    logic signed [95:0] a, b;
    logic signed [COORD_W-1:0] first, second;
    r = '{x: px, y: py, z: pz, last: last};
    if (rot_axis != AXIS_NONE) begin
      // the two free coordinates in ascending order
      a      = (rot_axis == AXIS_X) ? py : px;
      b      = (rot_axis == AXIS_Z) ? py : pz;
      first  = round_sat(cos_q * a - sin_q * b);
      second = round_sat(sin_q * a + cos_q * b);
      case (rot_axis)
        AXIS_X: begin
          r.y = first;
          r.z = second;
        end
        AXIS_Y: begin
          r.x = first;
          r.z = second;
        end
        default: begin
          r.x = first;
          r.y = second;
        end
      endcase
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rotated_point_t want;
    if (!rst_ni) begin
      rot_axis = AXIS_Z;
      cos_q    = TRIG_UNITY;
      sin_q    = '0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        n_writes++;
        if (reg_idx_e'(paddr[2]) == REG_AXIS_SEL) rot_axis = axis_e'(pwdata[AXIS_W-1:0]);
        else derive_trig(pwdata[ANGLE_W-1:0]);
      end
      if (pnt_in.valid && pnt_in.ready)
        expected_q.push_back(rotate_point(pnt_in.coord_x, pnt_in.coord_y,
                                          pnt_in.coord_z, pnt_in.batch_end));
      if (pnt_out.valid && pnt_out.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected rotated point, rot_x", '0, pnt_out.rot_x);
        end else begin
          want = expected_q.pop_front();
          cmp_count++;
          if (pnt_out.rot_x !== want.x) report_mismatch("rot_x", want.x, pnt_out.rot_x);
          if (pnt_out.rot_y !== want.y) report_mismatch("rot_y", want.y, pnt_out.rot_y);
          if (pnt_out.rot_z !== want.z) report_mismatch("rot_z", want.z, pnt_out.rot_z);
          if (pnt_out.batch_end_out !== want.last)
            report_mismatch("batch_end_out", 32'(want.last), 32'(pnt_out.batch_end_out));
        end
      end
    end
    // publish after the edge so readers at this edge see the old values
    fail_count     <= errs;
    pending        <= expected_q.size();
    points_checked <= cmp_count;
    writes_seen    <= n_writes;
  end

endmodule

[verif/tb_axis_point_rotator_core.sv]
`timescale 1ns / 100ps
// Top of the axis point rotator testbench: clock, reset, point and APB stimulus, verdict.
// Depends on axp_pkg, the point interfaces, axis_point_rotator_core and axp_rotation_checker.

module tb_axis_point_rotator_core;
  import axp_pkg::*;

  localparam int unsigned  WATCHDOG_LIMIT = 1000;
  localparam int unsigned  SEG_POINTS     = 211;
  localparam logic [31:0]  C_MAX          = 32'h7FFF_FFFF;
  localparam logic [31:0]  C_MIN          = 32'h8000_0000;
  localparam logic [0:8][31:0] SEG_ANGLES = {
    32'hFFFF_FFFF, 32'h4000_0000, 32'h4000_0001, 32'h8000_0000, 32'hBFFF_FFFF,
    32'hC000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000
  };

  logic               clk_i  = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 send_idle_pct = 33;
  int                 recv_idle_pct = 51;
  int                 quiet_cycles  = 0;
  int                 fail_count, pending, points_checked, writes_seen;

  axp_in_if  pnt_in ();
  axp_out_if pnt_out ();

  axis_point_rotator_core i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pnt_i   (pnt_in),
    .pnt_o   (pnt_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  axp_rotation_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pnt_in         (pnt_in),
    .pnt_out        (pnt_out),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .fail_count     (fail_count),
    .pending        (pending),
    .points_checked (points_checked),
    .writes_seen    (writes_seen)
  );

  always #6 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    pnt_out.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // end the run if nothing moves for too long
  always @(posedge clk_i) begin
    if ((pnt_in.valid && pnt_in.ready) || (pnt_out.valid && pnt_out.ready) ||
        (psel && penable)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d points outstanding",
               quiet_cycles, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic push_point(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input logic last);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      pnt_in.valid <= 1'b0;
      @(negedge clk_i);
    end
    pnt_in.valid     <= 1'b1;
    pnt_in.coord_x   <= x;
    pnt_in.coord_y   <= y;
    pnt_in.coord_z   <= z;
    pnt_in.batch_end <= last;
    do @(posedge clk_i); while (!pnt_in.ready);
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // drop valid, drain every outstanding point, then rewrite both registers
  task automatic set_rotation(input axis_e axis, input logic [31:0] angle);
    @(negedge clk_i);
    pnt_in.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    apb_write(REG_AXIS_SEL, 32'(axis));
    apb_write(REG_TURN_ANGLE, angle);
  endtask

  function automatic logic [31:0] rand_coord();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(3))
      0:       return {{12{r[31]}}, r[19:0]};
      1:       return r[31] ? C_MIN + r[7:0] : C_MAX - r[7:0];
      default: return r;
    endcase
  endfunction

  initial begin
    logic [31:0] angle;
    pnt_in.valid     = 1'b0;
    pnt_in.coord_x   = '0;
    pnt_in.coord_y   = '0;
    pnt_in.coord_z   = '0;
    pnt_in.batch_end = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // settings left by reset: z axis, angle zero
    push_point(32'h0, 32'h0, 32'h0, 1'b0);
    push_point(C_MAX, C_MIN, 32'h1, 1'b1);
    push_point(C_MIN, C_MAX, 32'hFFFF_FFFF, 1'b0);
    // eighth turn: diagonal extremes saturate
    set_rotation(AXIS_Z, 32'h2000_0000);
    push_point(C_MAX, C_MAX, 32'h0, 1'b0);
    push_point(C_MIN, C_MIN, 32'h5, 1'b1);
    push_point(C_MAX, C_MIN, C_MIN, 1'b0);
    push_point(32'h0001_0000, 32'h0, 32'h0, 1'b0);
    // beyond a quarter turn, negative side
    set_rotation(AXIS_X, 32'hA000_0000);
    push_point(32'h1, C_MAX, C_MIN, 1'b0);
    push_point(32'h7, 32'hFFFF_0000, 32'h0001_8000, 1'b1);
    push_point(32'h0, C_MIN, C_MIN, 1'b0);
    set_rotation(AXIS_Y, 32'h4000_0000);
    push_point(32'h0001_0000, 32'h3, 32'hFFFF_0000, 1'b0);
    push_point(C_MIN, 32'h0, C_MAX, 1'b1);
    set_rotation(AXIS_Y, 32'hFFFF_FFFF);
    push_point(C_MAX, 32'h1, C_MAX, 1'b0);
    push_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    // no axis: everything passes through
    set_rotation(AXIS_NONE, 32'h1234_5678);
    push_point(C_MAX, C_MIN, 32'h5555_5555, 1'b1);
    push_point(32'hFFFF_FFFD, 32'h2, 32'h0, 1'b0);

    for (int seg = 0; seg < 9; seg++) begin
      case (seg / 3)
        0: begin
          send_idle_pct = 33;
          recv_idle_pct = 51;
        end
        1: begin
          send_idle_pct = 51;
          recv_idle_pct = 33;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      angle = (seg == 6 || seg == 7) ? $urandom : SEG_ANGLES[seg];
      set_rotation(axis_e'(seg % 4), angle);
      repeat (SEG_POINTS)
        push_point(rand_coord(), rand_coord(), rand_coord(), $urandom_range(7) == 0);
    end

    @(negedge clk_i);
    pnt_in.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("checked %0d rotated points across %0d register writes,", points_checked,
             writes_seen);
    $display("covering all four axis settings, quarter-turn boundaries and three idling mixes");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
